/* src/triangle_unit_normal_macros.svh */
// Assertion macros shared by the triangle unit normal RTL.
// Files that check their own logic include this header; it needs nothing else.
`ifndef TRIANGLE_UNIT_NORMAL_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_MACROS_SVH
`ifndef SYNTHESIS
`define TUN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("triangle_unit_normal: check failed");
`define TUN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("triangle_unit_normal: implication failed");
`else
`define TUN_ASSERT(lbl, prop)
`define TUN_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

/* src/tun_pkg.sv */
// Shared types for the triangle unit normal block.
// Used by the top level and the per-component normalizer; depends on nothing.
`timescale 1ns / 1ps

package tun_pkg;

  typedef struct packed {
    logic valid;
    logic zero;
    logic neg;
  } tun_side_t;

endpackage

/* src/tun_norm_div.sv */
// Pipelined normalizer for one normal component: exact divide, then square root.
// Depends on tun_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "triangle_unit_normal_macros.svh"

module tun_norm_div
  import tun_pkg::*;
#(
  parameter int MAG_WIDTH = 100,
  parameter int FRAC_BITS = 15
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  tun_side_t                   side_i,
  input  logic [MAG_WIDTH-1:0]        m2_i,
  input  logic [MAG_WIDTH+1:0]        s_i,
  output tun_side_t                   side_o,
  output logic signed [FRAC_BITS:0]   norm_o
);

  localparam int SW  = MAG_WIDTH + 2;
  localparam int QW  = 2 * FRAC_BITS + 3;
  localparam int DW  = SW + QW;
  localparam int RT  = FRAC_BITS + 2;
  localparam int RMW = RT + 3;

  logic [DW-1:0] drem_q  [QW];
  logic [QW-1:0] dq_q    [QW];
  logic [SW-1:0] ds_q    [QW];
  tun_side_t     dside_q [QW];

  logic [QW-1:0]  sq_q    [RT];
  logic [RT-1:0]  root_q  [RT];
  logic [RMW-1:0] srem_q  [RT];
  tun_side_t      sside_q [RT];

  logic signed [FRAC_BITS:0] norm_q;
  tun_side_t                 side_q;

  for (genvar t = 0; t < QW; t++) begin : g_div
    logic [DW-1:0] rem_in;
    logic [DW-1:0] dvs;
    logic [QW-1:0] q_in;
    logic [SW-1:0] s_in;
    tun_side_t     sd_in;
    logic          ge;

    if (t == 0) begin : g_first
      assign rem_in = DW'(m2_i) << (2 * FRAC_BITS + 2);
      assign q_in   = '0;
      assign s_in   = s_i;
      assign sd_in  = side_i;
    end else begin : g_next
      assign rem_in = drem_q[t-1];
      assign q_in   = dq_q[t-1];
      assign s_in   = ds_q[t-1];
      assign sd_in  = dside_q[t-1];
    end

    assign dvs = DW'(s_in) << (QW - 1 - t);
    assign ge  = rem_in >= dvs;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dside_q[t] <= '0;
      end else if (en_i) begin
        dside_q[t] <= sd_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        drem_q[t] <= ge ? rem_in - dvs : rem_in;
        dq_q[t]   <= {q_in[QW-2:0], ge};
        ds_q[t]   <= s_in;
      end
    end
  end

  for (genvar u = 0; u < RT; u++) begin : g_sqrt
    logic [QW-1:0]   q_in;
    logic [RT-1:0]   root_in;
    logic [RMW-1:0]  rem_in;
    tun_side_t       sd_in;
    logic [2*RT-1:0] qp;
    logic [1:0]      pair;
    logic [RMW-1:0]  remn;
    logic [RMW-1:0]  trial;
    logic            ge;

    if (u == 0) begin : g_first
      assign q_in    = dq_q[QW-1];
      assign root_in = '0;
      assign rem_in  = '0;
      assign sd_in   = dside_q[QW-1];
    end else begin : g_next
      assign q_in    = sq_q[u-1];
      assign root_in = root_q[u-1];
      assign rem_in  = srem_q[u-1];
      assign sd_in   = sside_q[u-1];
    end

    assign qp    = {1'b0, q_in};
    assign pair  = qp[2*(RT-1-u) +: 2];
    assign remn  = {rem_in[RMW-3:0], pair};
    assign trial = RMW'({root_in, 2'b01});
    assign ge    = remn >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sside_q[u] <= '0;
      end else if (en_i) begin
        sside_q[u] <= sd_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[u]   <= q_in;
        srem_q[u] <= ge ? remn - trial : remn;
        root_q[u] <= {root_in[RT-2:0], ge};
      end
    end
  end

  logic [RT:0]          rnd;
  logic [FRAC_BITS:0]   k;
  logic [FRAC_BITS:0]   ks;
  logic [FRAC_BITS:0]   full;

  assign full = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  assign rnd  = ({1'b0, root_q[RT-1]} + (RT + 1)'(1)) >> 1;
  assign k    = rnd[FRAC_BITS:0];

  always_comb begin
    ks = k;
    if (!sside_q[RT-1].neg && k == full) begin
      ks = full - (FRAC_BITS + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= sside_q[RT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (sside_q[RT-1].zero) begin
        norm_q <= '0;
      end else if (sside_q[RT-1].neg) begin
        norm_q <= $signed(-ks);
      end else begin
        norm_q <= $signed(ks);
      end
    end
  end

  assign side_o = side_q;
  assign norm_o = norm_q;

  `TUN_ASSERT_IMPL(a_quot_bound, dside_q[QW-1].valid && !dside_q[QW-1].zero, dq_q[QW-1] <= (QW'(1) << (2 * FRAC_BITS + 2)))
  `TUN_ASSERT_IMPL(a_root_bound, sside_q[RT-1].valid && !sside_q[RT-1].zero, root_q[RT-1] <= (RT'(1) << (FRAC_BITS + 1)))
  `TUN_ASSERT_IMPL(a_zero_out, side_q.valid && side_q.zero, norm_q == '0)

endmodule

/* src/triangle_unit_normal.sv */
// Unit face normal of a triangle: edges, exact cross product, exact normalize.
// The pipeline runs through six front stages, one stage per quotient bit of the
// divider, one per root bit of the square root and an output register; one
// triangle word enters every cycle, and a stalled output word freezes the whole
// pipeline until it is taken.
// Depends on tun_pkg, tun_norm_div and the assertion macro header.
`timescale 1ns / 1ps
`include "triangle_unit_normal_macros.svh"

module triangle_unit_normal
  import tun_pkg::*;
#(
  parameter int COORD_WIDTH      = 24,
  parameter int NORMAL_FRAC_BITS = 15
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic signed [COORD_WIDTH-1:0]     a_x_i,
  input  logic signed [COORD_WIDTH-1:0]     a_y_i,
  input  logic signed [COORD_WIDTH-1:0]     a_z_i,
  input  logic signed [COORD_WIDTH-1:0]     b_x_i,
  input  logic signed [COORD_WIDTH-1:0]     b_y_i,
  input  logic signed [COORD_WIDTH-1:0]     b_z_i,
  input  logic signed [COORD_WIDTH-1:0]     c_x_i,
  input  logic signed [COORD_WIDTH-1:0]     c_y_i,
  input  logic signed [COORD_WIDTH-1:0]     c_z_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic signed [NORMAL_FRAC_BITS:0]  norm_x_o,
  output logic signed [NORMAL_FRAC_BITS:0]  norm_y_o,
  output logic signed [NORMAL_FRAC_BITS:0]  norm_z_o,
  output logic                              degenerate_o
);

  localparam int EW = COORD_WIDTH + 1;
  localparam int PW = 2 * EW;
  localparam int NW = PW;
  localparam int H  = (NW + 1) / 2;
  localparam int HI = NW - H;
  localparam int MW = 2 * NW;
  localparam int SW = MW + 2;

  logic en;
  logic [5:0] v_q;

  logic signed [COORD_WIDTH-1:0] a [3];
  logic signed [COORD_WIDTH-1:0] b [3];
  logic signed [COORD_WIDTH-1:0] c [3];

  logic signed [EW-1:0] e0_q [3];
  logic signed [EW-1:0] e1_q [3];
  logic signed [PW-1:0] p_q  [6];
  logic [NW-1:0]        mag_q [3];
  logic [2:0]           neg3_q, neg4_q, neg5_q, neg6_q;
  logic [2:0]           zero3_q;
  logic                 deg4_q, deg5_q, deg6_q;
  logic [2*HI-1:0]      hh_q [3];
  logic [HI+H-1:0]      hl_q [3];
  logic [2*H-1:0]       ll_q [3];
  logic [MW-1:0]        m2_q  [3];
  logic [MW-1:0]        m2s_q [3];
  logic [SW-1:0]        s_q;

  tun_side_t side_in [3];
  tun_side_t side_out [3];
  logic signed [NORMAL_FRAC_BITS:0] nrm [3];

  assign a = '{a_x_i, a_y_i, a_z_i};
  assign b = '{b_x_i, b_y_i, b_z_i};
  assign c = '{c_x_i, c_y_i, c_z_i};

  assign en      = !(valid_o && stall_i);
  assign stall_o = valid_o && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        e0_q[j] <= {b[j][COORD_WIDTH-1], b[j]} - {a[j][COORD_WIDTH-1], a[j]};
        e1_q[j] <= {c[j][COORD_WIDTH-1], c[j]} - {a[j][COORD_WIDTH-1], a[j]};
      end
      p_q[0] <= e0_q[1] * e1_q[2];
      p_q[1] <= e0_q[2] * e1_q[1];
      p_q[2] <= e0_q[2] * e1_q[0];
      p_q[3] <= e0_q[0] * e1_q[2];
      p_q[4] <= e0_q[0] * e1_q[1];
      p_q[5] <= e0_q[1] * e1_q[0];
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_comp
    logic signed [PW:0] n;
    logic [PW:0]        nabs;
    logic [NW-1:0]      hm;

    assign n    = {p_q[2*j][PW-1], p_q[2*j]} - {p_q[2*j+1][PW-1], p_q[2*j+1]};
    assign nabs = n[PW] ? -n : n;
    assign hm   = mag_q[j];

    always_ff @(posedge clk_i) begin
      if (en) begin
        mag_q[j]   <= nabs[NW-1:0];
        neg3_q[j]  <= n[PW];
        zero3_q[j] <= n == '0;
        hh_q[j]    <= hm[NW-1:H] * hm[NW-1:H];
        hl_q[j]    <= hm[NW-1:H] * hm[H-1:0];
        ll_q[j]    <= hm[H-1:0] * hm[H-1:0];
        m2_q[j]    <= (MW'(hh_q[j]) << (2 * H)) + (MW'(hl_q[j]) << (H + 1))
                      + MW'(ll_q[j]);
        m2s_q[j]   <= m2_q[j];
      end
    end

    assign side_in[j] = '{valid: v_q[5], zero: deg6_q, neg: neg6_q[j]};

    tun_norm_div #(
      .MAG_WIDTH (MW),
      .FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .side_i (side_in[j]),
      .m2_i   (m2s_q[j]),
      .s_i    (s_q),
      .side_o (side_out[j]),
      .norm_o (nrm[j])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg4_q <= neg3_q;
      neg5_q <= neg4_q;
      neg6_q <= neg5_q;
      deg4_q <= &zero3_q;
      deg5_q <= deg4_q;
      deg6_q <= deg5_q;
      s_q    <= SW'(m2_q[0]) + SW'(m2_q[1]) + SW'(m2_q[2]);
    end
  end

  assign valid_o      = side_out[0].valid;
  assign degenerate_o = side_out[0].zero;
  assign norm_x_o     = nrm[0];
  assign norm_y_o     = nrm[1];
  assign norm_z_o     = nrm[2];

  `TUN_ASSERT(a_lanes_agree, side_out[0].valid == side_out[1].valid && side_out[0].valid == side_out[2].valid)
  `TUN_ASSERT_IMPL(a_deg_agree, valid_o, side_out[1].zero == degenerate_o && side_out[2].zero == degenerate_o)
  `TUN_ASSERT_IMPL(a_nonzero, valid_o && !degenerate_o, norm_x_o != '0 || norm_y_o != '0 || norm_z_o != '0)

endmodule
